>>> sv/ggc_pkg.sv
// Shared constants, types and functions of the greedy graph coloring core.
package ggc_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int MAX_COLORS = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int COLOR_W    = $clog2(MAX_COLORS);
  localparam int TOTAL_W    = COLOR_W + 1;
  localparam int CNT_W      = NODE_W + 1;
  localparam int MQ_DEPTH   = 4;
  localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

  typedef struct packed {
    logic [NODE_W-1:0] nb;
    logic              mark;
    logic              last;
    logic [NODE_W-1:0] node;
    logic              final_node;
  } ggc_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_index;
    logic [COLOR_W-1:0] node_color;
    logic               opened_group;
    logic [TOTAL_W-1:0] colors_used;
    logic               final_node;
    logic               palette_overflow;
  } ggc_res_t;

  // Top bit set when every color is taken, lower bits hold the lowest free color.
  function automatic logic [COLOR_W:0] first_free(input logic [MAX_COLORS-1:0] mask);
    logic [COLOR_W:0] res;
    res = {1'b1, {COLOR_W{1'b1}}};
    for (int i = MAX_COLORS - 1; i >= 0; i--) begin
      if (!mask[i]) begin
        res = {1'b0, COLOR_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

>>> sv/greedy_graph_coloring_core.sv
// Greedy sequential graph coloring core. Push one neighbor per item; the item
// flagged last_of_node closes the node and yields one result with its color.
// Throughput is one item per clock while the result queue has room, including
// an item that reads the color of the node closed in the cycle before. The rate
// is set by the color store, which is read once per cycle at the neighbor index
// and written once per closed node. A result passes through the command queue,
// the s2 register and the result queue before it reaches the result ports.
// The color store holds no reset state and needs no clearing after reset.
module greedy_graph_coloring_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ggc_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [ggc_pkg::NODE_W-1:0]    neighbor_index_i,
  input  logic                          has_neighbor_i,
  input  logic                          last_of_node_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ggc_pkg::NODE_W-1:0]    node_index_o,
  output logic [ggc_pkg::COLOR_W-1:0]   node_color_o,
  output logic                          opened_group_o,
  output logic [ggc_pkg::TOTAL_W-1:0]   colors_used_o,
  output logic                          final_node_o,
  output logic                          palette_overflow_o
);
  import ggc_pkg::*;

  ggc_cmd_t in_cmd, q_cmd;
  logic     mq_push, mq_full, mq_valid, mq_pop;

  ggc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .neighbor_index_i (neighbor_index_i),
    .has_neighbor_i   (has_neighbor_i),
    .last_of_node_i   (last_of_node_i),
    .mq_full_i        (mq_full),
    .mq_push_o        (mq_push),
    .mq_cmd_o         (in_cmd)
  );

  ggc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .cmd_i   (in_cmd),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .valid_o (mq_valid),
    .cmd_o   (q_cmd)
  );

  ggc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .mq_valid_i         (mq_valid),
    .mq_cmd_i           (q_cmd),
    .mq_pop_o           (mq_pop),
    .empty              (empty),
    .pop                (pop),
    .node_index_o       (node_index_o),
    .node_color_o       (node_color_o),
    .opened_group_o     (opened_group_o),
    .colors_used_o      (colors_used_o),
    .final_node_o       (final_node_o),
    .palette_overflow_o (palette_overflow_o)
  );

endmodule

>>> sv/ggc_front.sv
// Front end: run length register, node tracking and neighbor classification.
module ggc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ggc_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic [ggc_pkg::NODE_W-1:0] neighbor_index_i,
  input  logic                       has_neighbor_i,
  input  logic                       last_of_node_i,
  input  logic                       mq_full_i,
  output logic                       mq_push_o,
  output ggc_pkg::ggc_cmd_t          mq_cmd_o
);
  import ggc_pkg::*;

  logic [CNT_W-1:0]  node_count_q;
  logic [NODE_W-1:0] node_q, node_d;
  logic [CNT_W-1:0]  len;
  logic              is_final;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign full        = mq_full_i;
  assign accept      = push && !mq_full_i;
  assign mq_push_o   = accept;

  always_comb begin
    if (node_count_q == '0) begin
      len = CNT_W'(1);
    end else if (node_count_q > NODE_COUNT_RESET) begin
      len = NODE_COUNT_RESET;
    end else begin
      len = node_count_q;
    end
  end

  assign is_final = ({1'b0, node_q} + CNT_W'(1)) >= len;

  always_comb begin
    mq_cmd_o.nb         = neighbor_index_i;
    mq_cmd_o.mark       = has_neighbor_i && (neighbor_index_i < node_q) &&
                          ({1'b0, neighbor_index_i} < len);
    mq_cmd_o.last       = last_of_node_i;
    mq_cmd_o.node       = node_q;
    mq_cmd_o.final_node = is_final;
  end

  always_comb begin
    node_d = node_q;
    if (accept && last_of_node_i) begin
      node_d = is_final ? '0 : node_q + NODE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
      node_q       <= '0;
    end else begin
      node_q <= node_d;
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

endmodule

>>> sv/ggc_queue.sv
// Command queue between the front end and the coloring back end.
module ggc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ggc_pkg::ggc_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ggc_pkg::ggc_cmd_t cmd_o
);
  import ggc_pkg::*;

  ggc_cmd_t            mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_q, rd_q;
  logic [MQ_PTR_W:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (MQ_PTR_W + 1)'(MQ_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + MQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + MQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (MQ_PTR_W + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (MQ_PTR_W + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/ggc_back.sv
// Back end: color store, forbidden mask, color choice and result queue.
module ggc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          mq_valid_i,
  input  ggc_pkg::ggc_cmd_t             mq_cmd_i,
  output logic                          mq_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [ggc_pkg::NODE_W-1:0]    node_index_o,
  output logic [ggc_pkg::COLOR_W-1:0]   node_color_o,
  output logic                          opened_group_o,
  output logic [ggc_pkg::TOTAL_W-1:0]   colors_used_o,
  output logic                          final_node_o,
  output logic                          palette_overflow_o
);
  import ggc_pkg::*;

  logic [COLOR_W-1:0]    store_q [MAX_NODES];
  ggc_cmd_t              s2_q;
  logic                  s2_valid_q;
  logic [COLOR_W-1:0]    rdata_q;
  logic                  fwd_valid_q;
  logic [NODE_W-1:0]     fwd_node_q;
  logic [COLOR_W-1:0]    fwd_color_q;
  logic [MAX_COLORS-1:0] mask_q, mask_eff;
  logic [TOTAL_W-1:0]    total_q, total_new;
  logic [COLOR_W-1:0]    nb_color, chosen;
  logic [COLOR_W:0]      pick;
  logic                  ovf, opened;
  logic                  retire, load, wr_en;

  ggc_res_t              oq_q [2];
  logic                  oq_wr_q, oq_rd_q;
  logic [1:0]            oq_cnt_q;
  logic                  oq_pop;
  ggc_res_t              res;

  assign nb_color  = (fwd_valid_q && fwd_node_q == s2_q.nb) ? fwd_color_q : rdata_q;
  assign mask_eff  = mask_q | (s2_q.mark ?
                     ({{(MAX_COLORS-1){1'b0}}, 1'b1} << nb_color) : '0);
  assign pick      = first_free(mask_eff);
  assign chosen    = pick[COLOR_W-1:0];
  assign ovf       = pick[COLOR_W];
  assign opened    = !ovf && ({1'b0, chosen} >= total_q);
  assign total_new = opened ? {1'b0, chosen} + TOTAL_W'(1) : total_q;

  assign retire   = s2_valid_q && (!s2_q.last || oq_cnt_q != 2'd2);
  assign wr_en    = retire && s2_q.last;
  assign load     = mq_valid_i && (!s2_valid_q || retire);
  assign mq_pop_o = load;

  always_comb begin
    res.node_index       = s2_q.node;
    res.node_color       = chosen;
    res.opened_group     = opened;
    res.colors_used      = total_new;
    res.final_node       = s2_q.final_node;
    res.palette_overflow = ovf;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[s2_q.node] <= chosen;
    end
    if (load) begin
      rdata_q     <= store_q[mq_cmd_i.nb];
      s2_q        <= mq_cmd_i;
      fwd_node_q  <= s2_q.node;
      fwd_color_q <= chosen;
    end
    if (wr_en) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      mask_q      <= '0;
      total_q     <= '0;
    end else begin
      s2_valid_q <= load || (s2_valid_q && !retire);
      if (load) begin
        fwd_valid_q <= wr_en;
      end
      if (retire) begin
        mask_q <= s2_q.last ? '0 : mask_eff;
      end
      if (wr_en) begin
        total_q <= s2_q.final_node ? '0 : total_new;
      end
    end
  end

  assign empty  = oq_cnt_q == 2'd0;
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      case ({wr_en, oq_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  assign node_index_o       = oq_q[oq_rd_q].node_index;
  assign node_color_o       = oq_q[oq_rd_q].node_color;
  assign opened_group_o     = oq_q[oq_rd_q].opened_group;
  assign colors_used_o      = oq_q[oq_rd_q].colors_used;
  assign final_node_o       = oq_q[oq_rd_q].final_node;
  assign palette_overflow_o = oq_q[oq_rd_q].palette_overflow;

endmodule

>>> verif/ggc_checker.sv
// Transfer monitor, coloring predictor and result comparison for the coloring core.
`timescale 1ns / 100ps
module ggc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [ggc_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [ggc_pkg::NODE_W-1:0]  neighbor_index_i,
  input  logic                        has_neighbor_i,
  input  logic                        last_of_node_i,
  input  logic                        pop_i,
  input  logic                        empty_i,
  input  logic [ggc_pkg::NODE_W-1:0]  node_index_i,
  input  logic [ggc_pkg::COLOR_W-1:0] node_color_i,
  input  logic                        opened_group_i,
  input  logic [ggc_pkg::TOTAL_W-1:0] colors_used_i,
  input  logic                        final_node_i,
  input  logic                        palette_overflow_i,
  output int                          errors_o,
  output int                          pending_o
);
  import ggc_pkg::*;

  logic [COLOR_W-1:0]    color_mem [MAX_NODES];
  logic [MAX_COLORS-1:0] banned;
  logic [NODE_W-1:0]     node_at;
  logic [TOTAL_W-1:0]    groups_open;
  logic [CNT_W-1:0]      length_reg;
  ggc_res_t              colorings_due [$];
  int                    mismatches = 0;

  assign errors_o = mismatches;

  function automatic logic [CNT_W-1:0] active_length(input logic [CNT_W-1:0] raw);
    if (raw == '0) return CNT_W'(1);
    if (raw > CNT_W'(MAX_NODES)) return CNT_W'(MAX_NODES);
    return raw;
  endfunction

  task automatic color_item(input logic [NODE_W-1:0] nb, input logic has, input logic last);
    logic [CNT_W-1:0]   span;
    logic [COLOR_W-1:0] pick;
    logic               palette_full;
    ggc_res_t           res;
    span = active_length(length_reg);
    if (has && nb < node_at && CNT_W'(nb) < span) begin
      banned[color_mem[nb]] = 1'b1;
    end
    if (last) begin
      palette_full = 1'b1;
      pick = COLOR_W'(MAX_COLORS - 1);
      for (int c = 0; c < MAX_COLORS; c++) begin
        if (palette_full && !banned[c]) begin
          pick = COLOR_W'(c);
          palette_full = 1'b0;
        end
      end
      res.opened_group = !palette_full && (TOTAL_W'(pick) >= groups_open);
      if (res.opened_group) begin
        groups_open = TOTAL_W'(pick) + TOTAL_W'(1);
      end
      color_mem[node_at] = pick;
      res.node_index = node_at;
      res.node_color = pick;
      res.colors_used = groups_open;
      res.final_node = (CNT_W'(node_at) + CNT_W'(1)) >= span;
      res.palette_overflow = palette_full;
      colorings_due = {colorings_due, res};
      banned = '0;
      if (res.final_node) begin
        node_at = '0;
        groups_open = '0;
      end else begin
        node_at = node_at + NODE_W'(1);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ggc_res_t due;
    if (!rst_ni) begin
      banned = '0;
      node_at = '0;
      groups_open = '0;
      length_reg = NODE_COUNT_RESET;
      colorings_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        length_reg = cfg_data_i;
      end
      if (push_i && !full_i) begin
        color_item(neighbor_index_i, has_neighbor_i, last_of_node_i);
      end
      if (pop_i && !empty_i) begin
        if (colorings_due.size() == 0) begin
          $error("result transfer with no coloring due: node_index %0d", node_index_i);
          mismatches++;
        end else begin
          due = colorings_due.pop_front();
          check_field("node_index", due.node_index, node_index_i);
          check_field("node_color", due.node_color, node_color_i);
          check_field("opened_group", due.opened_group, opened_group_i);
          check_field("colors_used", due.colors_used, colors_used_i);
          check_field("final_node", due.final_node, final_node_i);
          check_field("palette_overflow", due.palette_overflow, palette_overflow_i);
        end
      end
      pending_o <= colorings_due.size();
    end
  end

endmodule

>>> verif/tb_greedy_graph_coloring_core.sv
// Clock, reset, stimulus, watchdog and verdict for the greedy graph coloring core.
`timescale 1ns / 100ps
module tb_greedy_graph_coloring_core;
  import ggc_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CLIQUE_NODES = 12;
  localparam int LONG_NODES   = 200;
  localparam int PHASE_ITEMS  = 30;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CNT_W-1:0]   cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [NODE_W-1:0]  neighbor_index_i = '0;
  logic               has_neighbor_i = 1'b0;
  logic               last_of_node_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [NODE_W-1:0]  node_index_o;
  logic [COLOR_W-1:0] node_color_o;
  logic               opened_group_o;
  logic [TOTAL_W-1:0] colors_used_o;
  logic               final_node_o;
  logic               palette_overflow_o;

  int errors;
  int pending;
  int stall_cycles = 0;
  bit steady = 1'b0;
  int at_node = 0;
  int run_span = MAX_NODES;
  int items_sent = 0;

  greedy_graph_coloring_core DUT (.*);

  ggc_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .push_i             (push),
    .full_i             (full),
    .neighbor_index_i   (neighbor_index_i),
    .has_neighbor_i     (has_neighbor_i),
    .last_of_node_i     (last_of_node_i),
    .pop_i              (pop),
    .empty_i            (empty),
    .node_index_i       (node_index_o),
    .node_color_i       (node_color_o),
    .opened_group_i     (opened_group_o),
    .colors_used_i      (colors_used_o),
    .final_node_i       (final_node_o),
    .palette_overflow_i (palette_overflow_o),
    .errors_o           (errors),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 6);
  endfunction

  always @(posedge clk_i) begin
    pop <= !take_gap();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_greedy_graph_coloring_core: errors");
        $finish;
      end
    end
  end

  task automatic send(input int nb, input bit has, input bit last);
    while (take_gap()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    neighbor_index_i <= NODE_W'(nb);
    has_neighbor_i <= has;
    last_of_node_i <= last;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (last) begin
      at_node = (at_node + 1 >= run_span) ? 0 : at_node + 1;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_length(input int raw);
    wait_idle();
    cfg_data_i <= CNT_W'(raw);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    run_span = (raw == 0) ? 1 : ((raw > MAX_NODES) ? MAX_NODES : raw);
  endtask

  // Mostly neighbors that are already colored, some drawn from the whole index range.
  task automatic close_node(input int count);
    int nb;
    bit has;
    if (count == 0) begin
      send($urandom_range(0, MAX_NODES - 1), 1'b0, 1'b1);
      return;
    end
    for (int k = 0; k < count; k++) begin
      has = ($urandom_range(0, 9) != 0);
      if (at_node > 0 && $urandom_range(0, 4) != 0) begin
        nb = $urandom_range(0, at_node - 1);
      end else begin
        nb = $urandom_range(0, MAX_NODES - 1);
      end
      send(nb, has, k == count - 1);
    end
  endtask

  // Each node sees all earlier nodes, so each node opens one more color.
  task automatic build_clique();
    int order [CLIQUE_NODES];
    int j;
    int tmp;
    for (int n = 0; n < CLIQUE_NODES; n++) begin
      if (n == 0) begin
        send(0, 1'b0, 1'b1);
      end else begin
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        if ($urandom_range(0, 3) == 0) begin
          send($urandom_range(n, MAX_NODES - 1), 1'b1, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
          send(order[0], 1'b1, 1'b0);
        end
        for (int k = 0; k < n; k++) begin
          send(order[k], 1'b1, k == n - 1);
        end
      end
    end
  endtask

  initial begin
    int phase_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(0, 1'b0, 1'b1);
    send(MAX_NODES - 1, 1'b0, 1'b0);
    send(0, 1'b1, 1'b1);
    send(MAX_NODES - 1, 1'b1, 1'b0);
    send(2, 1'b1, 1'b0);
    send(1, 1'b1, 1'b0);
    send(0, 1'b1, 1'b1);
    send(1, 1'b1, 1'b0);
    send(1, 1'b1, 1'b1);
    send(3, 1'b0, 1'b1);
    send(3, 1'b1, 1'b0);
    send(4, 1'b1, 1'b0);
    send(2, 1'b1, 1'b1);

    // shrink the run below the current node
    set_length(3);
    send(5, 1'b1, 1'b1);

    set_length(0);
    send(0, 1'b1, 1'b1);
    send(MAX_NODES / 2, 1'b1, 1'b1);

    set_length(CLIQUE_NODES);
    build_clique();

    set_length((1 << CNT_W) - 1);
    for (int i = 0; i < LONG_NODES; i++) begin
      steady = (i >= 50 && i < 150);
      close_node(($urandom_range(0, 7) == 0) ? 2 : 1);
    end
    steady = 1'b0;

    for (int p = 0; p < 5; p++) begin
      if (p == 0) begin
        set_length(1);
      end else begin
        case ($urandom_range(0, 4))
          0: set_length(2);
          1: set_length($urandom_range(3, 12));
          2: set_length($urandom_range(13, 80));
          3: set_length(MAX_NODES);
          default: set_length(0);
        endcase
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send($urandom_range(0, MAX_NODES - 1), 1'b0, 1'b0);
        end else begin
          close_node($urandom_range(0, 5));
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_greedy_graph_coloring_core: clean");
    end else begin
      $display("tb_greedy_graph_coloring_core: errors");
    end
    $finish;
  end

endmodule
